// File: rtl/arpr_pkg.sv
// Shared types and constants for the ARP resolver.
// Holds the item/result structs and the controller-datapath command/status structs.
// No dependencies.
package arpr_pkg;

	localparam logic [1:0] ACT_SEND   = 2'd0;
	localparam logic [1:0] ACT_FRAME  = 2'd1;
	localparam logic [1:0] ACT_TICK   = 2'd2;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam logic [1:0] FK_IPV4   = 2'd0;
	localparam logic [1:0] FK_ARP    = 2'd1;
	localparam logic [1:0] FK_OTHER  = 2'd2;
	localparam logic [1:0] FK_UNUSED = 2'd3;

	localparam logic [1:0] OP_REQ   = 2'd0;
	localparam logic [1:0] OP_REP   = 2'd1;
	localparam logic [1:0] OP_OTHER = 2'd2;

	localparam logic [1:0] RES_IPV4 = 2'd0;
	localparam logic [1:0] RES_ARP  = 2'd1;
	localparam logic [1:0] RES_DLV  = 2'd2;
	localparam logic [1:0] RES_NONE = 2'd3;

	localparam logic [1:0] CFG_OWN_MAC  = 2'd0;
	localparam logic [1:0] CFG_OWN_IP   = 2'd1;
	localparam logic [1:0] CFG_LIFETIME = 2'd2;
	localparam logic [1:0] CFG_HOLDOFF  = 2'd3;

	localparam logic [47:0] BCAST_MAC        = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] LIFETIME_DEFAULT = 32'd30000;
	localparam logic [31:0] HOLDOFF_DEFAULT  = 32'd5000;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] datagram_handle;
		logic [31:0] next_hop_addr;
		logic [47:0] frame_dst_mac;
		logic [1:0]  frame_kind;
		logic        payload_ok;
		logic [1:0]  arp_op;
		logic [31:0] arp_sender_ip;
		logic [47:0] arp_sender_mac;
		logic [31:0] arp_target_ip;
		logic [31:0] elapsed_ms;
	} item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [47:0] out_dst_mac;
		logic        out_arp_op;
		logic [31:0] out_arp_target_ip;
		logic [47:0] out_arp_target_mac;
		logic [15:0] out_handle;
		logic        last_result;
	} result_t;

	typedef struct packed {
		logic latch;
		logic clk_add;
		logic ld_send;
		logic ld_learn;
		logic ld_reply;
		logic ld_req;
		logic ld_q;
		logic scan_start;
		logic scan_hold;
		logic cache_wr;
		logic hold_wr;
		logic q_push;
		logic rr_init;
		logic emit_ipv4;
		logic emit_arp;
		logic emit_dlv;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic is_send;
		logic is_tick;
		logic is_deliver;
		logic is_learn;
		logic is_arp_other;
		logic reply_needed;
		logic scan_done;
		logic hit;
		logic fresh;
		logic held;
		logic q_more;
	} sts_t;

endpackage

// File: rtl/arp_resolver_with_pending_queue.sv
// ARP resolver top level: controller plus datapath.
// A tick or a delivered or ignored frame is decoded and then finishes; a send walks the
// cache and, on a miss or stale hit, the holdoff table; a queue re-run walks the cache for
// each queued datagram, and the holdoff table as well when it needs a request.
// One transaction at a time; busy drops as the final result is staged, so the next start
// is taken in the cycle the final result shows. The receiver cannot stall.
// Reset clears valid bits, queue count and clock and loads register defaults; no clearing pass.
module arp_resolver_with_pending_queue #(
	parameter int CACHE_ENTRIES   = 16,
	parameter int HOLDOFF_ENTRIES = 16,
	parameter int QUEUE_DEPTH     = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  arpr_pkg::item_t   item,
	output logic              result_valid,
	output arpr_pkg::result_t result,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_idx,
	input  logic [47:0]       cfg_wdata
);

	arpr_pkg::cmd_t cmd;
	arpr_pkg::sts_t sts;

	arpr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	arpr_dp #(
		.CACHE_ENTRIES   (CACHE_ENTRIES),
		.HOLDOFF_ENTRIES (HOLDOFF_ENTRIES),
		.QUEUE_DEPTH     (QUEUE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result       (result)
	);

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last_result |-> !busy)
		else $error("final result while still busy");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_result |-> busy)
		else $error("non-final result outside a transaction");

endmodule

// File: rtl/arpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module arpr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/arpr_ctrl.sv
// Controller state machine for the ARP resolver.
// Depends on arpr_pkg (cmd_t, sts_t).
module arpr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  arpr_pkg::sts_t sts,
	output arpr_pkg::cmd_t cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DEC   = 4'd1;
	localparam logic [3:0] ST_CSCAN = 4'd2;
	localparam logic [3:0] ST_HSCAN = 4'd3;
	localparam logic [3:0] ST_LSCAN = 4'd4;
	localparam logic [3:0] ST_RRINI = 4'd5;
	localparam logic [3:0] ST_RRRD  = 4'd6;
	localparam logic [3:0] ST_RRLD  = 4'd7;
	localparam logic [3:0] ST_FIN   = 4'd8;

	logic [3:0] state_q, state_d;
	logic       ctx_send_q, ctx_send_d;
	logic       rerun_q, rerun_d;

	always_comb begin
		state_d    = state_q;
		ctx_send_d = ctx_send_q;
		rerun_d    = rerun_q;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					rerun_d   = 1'b0;
					state_d   = ST_DEC;
				end
			end
			ST_DEC: begin
				if (sts.is_send) begin
					cmd.ld_send    = 1'b1;
					cmd.scan_start = 1'b1;
					state_d        = ST_CSCAN;
				end else if (sts.is_tick) begin
					cmd.clk_add = 1'b1;
					state_d     = ST_FIN;
				end else if (sts.is_deliver) begin
					cmd.emit_dlv = 1'b1;
					state_d      = ST_FIN;
				end else if (sts.is_learn) begin
					cmd.ld_learn   = 1'b1;
					cmd.scan_start = 1'b1;
					state_d        = ST_LSCAN;
				end else if (sts.is_arp_other) begin
					state_d = ST_RRINI;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_CSCAN: begin
				if (sts.scan_done) begin
					if (sts.hit && sts.fresh) begin
						cmd.emit_ipv4 = 1'b1;
						state_d       = rerun_q ? ST_RRRD : ST_FIN;
					end else begin
						cmd.ld_req     = 1'b1;
						cmd.scan_start = 1'b1;
						cmd.scan_hold  = 1'b1;
						ctx_send_d     = 1'b1;
						state_d        = ST_HSCAN;
					end
				end
			end
			ST_HSCAN: begin
				if (sts.scan_done) begin
					if (!sts.held) begin
						cmd.hold_wr  = 1'b1;
						cmd.emit_arp = 1'b1;
					end
					if (ctx_send_q) begin
						cmd.q_push = 1'b1;
						state_d    = rerun_q ? ST_RRRD : ST_FIN;
					end else begin
						state_d = ST_RRINI;
					end
				end
			end
			ST_LSCAN: begin
				if (sts.scan_done) begin
					cmd.cache_wr = 1'b1;
					if (sts.reply_needed) begin
						cmd.ld_reply   = 1'b1;
						cmd.scan_start = 1'b1;
						cmd.scan_hold  = 1'b1;
						ctx_send_d     = 1'b0;
						state_d        = ST_HSCAN;
					end else begin
						state_d = ST_RRINI;
					end
				end
			end
			ST_RRINI: begin
				cmd.rr_init = 1'b1;
				rerun_d     = 1'b1;
				state_d     = ST_RRRD;
			end
			ST_RRRD: begin
				// queue read address is presented here, data lands next cycle
				state_d = sts.q_more ? ST_RRLD : ST_FIN;
			end
			ST_RRLD: begin
				cmd.ld_q       = 1'b1;
				cmd.scan_start = 1'b1;
				state_d        = ST_CSCAN;
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ctx_send_q <= 1'b0;
			rerun_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			ctx_send_q <= ctx_send_d;
			rerun_q    <= rerun_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// File: rtl/arpr_dp.sv
// Datapath for the ARP resolver: config registers, cache/holdoff/queue RAMs,
// the table scanner and the result staging. Depends on arpr_pkg and arpr_ram.
module arpr_dp #(
	parameter int CACHE_ENTRIES   = 16,
	parameter int HOLDOFF_ENTRIES = 16,
	parameter int QUEUE_DEPTH     = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_idx,
	input  logic [47:0]       cfg_wdata,
	input  arpr_pkg::item_t   item,
	input  arpr_pkg::cmd_t    cmd,
	output arpr_pkg::sts_t    sts,
	output logic              result_valid,
	output arpr_pkg::result_t result
);

	localparam int CW   = $clog2(CACHE_ENTRIES);
	localparam int HW   = $clog2(HOLDOFF_ENTRIES);
	localparam int QW   = $clog2(QUEUE_DEPTH);
	localparam int MAXD = (CACHE_ENTRIES > HOLDOFF_ENTRIES) ? CACHE_ENTRIES : HOLDOFF_ENTRIES;
	localparam int SW   = $clog2(MAXD + 1);
	localparam int NW   = $clog2(QUEUE_DEPTH + 1);

	// configuration
	logic [47:0] own_mac_q;
	logic [31:0] own_ip_q, lifetime_q, holdoff_q, clock_q;
	arpr_pkg::item_t item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q  <= '0;
			own_ip_q   <= '0;
			lifetime_q <= arpr_pkg::LIFETIME_DEFAULT;
			holdoff_q  <= arpr_pkg::HOLDOFF_DEFAULT;
			clock_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					arpr_pkg::CFG_OWN_MAC:  own_mac_q  <= cfg_wdata;
					arpr_pkg::CFG_OWN_IP:   own_ip_q   <= cfg_wdata[31:0];
					arpr_pkg::CFG_LIFETIME: lifetime_q <= cfg_wdata[31:0];
					arpr_pkg::CFG_HOLDOFF:  holdoff_q  <= cfg_wdata[31:0];
					default: ;
				endcase
			end
			if (cmd.clk_add) begin
				clock_q <= clock_q + item_q.elapsed_ms;
			end
		end
	end

	// item and current-work registers
	logic [31:0] cur_ip_q;
	logic [15:0] cur_handle_q;
	logic [47:0] cur_dst_q;
	logic        cur_op_q;
	logic [47:0] q_rdata;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= item;
		end
		if (cmd.ld_send) begin
			cur_ip_q     <= item_q.next_hop_addr;
			cur_handle_q <= item_q.datagram_handle;
		end
		if (cmd.ld_learn) begin
			cur_ip_q <= item_q.arp_sender_ip;
		end
		if (cmd.ld_reply) begin
			cur_ip_q  <= item_q.arp_sender_ip;
			cur_dst_q <= item_q.arp_sender_mac;
			cur_op_q  <= 1'b1;
		end
		if (cmd.ld_req) begin
			cur_dst_q <= arpr_pkg::BCAST_MAC;
			cur_op_q  <= 1'b0;
		end
		if (cmd.ld_q) begin
			cur_ip_q     <= q_rdata[31:0];
			cur_handle_q <= q_rdata[47:32];
		end
	end

	// item decode
	logic frame_ok, is_arp;
	assign frame_ok = (item_q.action == arpr_pkg::ACT_FRAME) && item_q.payload_ok
		&& ((item_q.frame_dst_mac == own_mac_q) || (item_q.frame_dst_mac == arpr_pkg::BCAST_MAC));
	assign is_arp = frame_ok && (item_q.frame_kind == arpr_pkg::FK_ARP);

	assign sts.is_send      = (item_q.action == arpr_pkg::ACT_SEND);
	assign sts.is_tick      = (item_q.action == arpr_pkg::ACT_TICK);
	assign sts.is_deliver   = frame_ok && (item_q.frame_kind == arpr_pkg::FK_IPV4);
	assign sts.is_learn     = is_arp && ((item_q.arp_op == arpr_pkg::OP_REQ)
		|| (item_q.arp_op == arpr_pkg::OP_REP));
	assign sts.is_arp_other = is_arp && !sts.is_learn;
	assign sts.reply_needed = (item_q.arp_op == arpr_pkg::OP_REQ)
		&& (item_q.arp_target_ip == own_ip_q);

	// tables
	logic [CACHE_ENTRIES-1:0]   cache_valid_q;
	logic [HOLDOFF_ENTRIES-1:0] hold_valid_q;
	logic [111:0] cache_rdata;
	logic [63:0]  hold_rdata;
	logic [CW-1:0] c_slot;
	logic [HW-1:0] h_slot;

	// scanner state
	logic          scan_active_q, scan_sel_q, chk_vld_s1, hit_q, best_set_q;
	logic [SW-1:0] iss_q, chk_idx_s1, hit_idx_q, oldest_q, scan_len;
	logic [31:0]   best_q, hit_stamp_q;
	logic [47:0]   hit_mac_q;

	arpr_ram #(.WIDTH(112), .DEPTH(CACHE_ENTRIES)) u_cache_ram (
		.clk   (clk),
		.we    (cmd.cache_wr),
		.waddr (c_slot),
		.wdata ({cur_ip_q, item_q.arp_sender_mac, clock_q}),
		.raddr (iss_q[CW-1:0]),
		.rdata (cache_rdata)
	);

	arpr_ram #(.WIDTH(64), .DEPTH(HOLDOFF_ENTRIES)) u_hold_ram (
		.clk   (clk),
		.we    (cmd.hold_wr),
		.waddr (h_slot),
		.wdata ({cur_ip_q, clock_q}),
		.raddr (iss_q[HW-1:0]),
		.rdata (hold_rdata)
	);

	assign scan_len = scan_sel_q ? SW'(HOLDOFF_ENTRIES) : SW'(CACHE_ENTRIES);

	logic [31:0] chk_ip, chk_stamp, chk_age;
	logic        chk_v;
	assign chk_ip    = scan_sel_q ? hold_rdata[63:32] : cache_rdata[111:80];
	assign chk_stamp = scan_sel_q ? hold_rdata[31:0] : cache_rdata[31:0];
	assign chk_v     = scan_sel_q ? hold_valid_q[chk_idx_s1[HW-1:0]]
		: cache_valid_q[chk_idx_s1[CW-1:0]];
	assign chk_age   = clock_q - chk_stamp;

	assign sts.scan_done = scan_active_q && (iss_q == scan_len) && !chk_vld_s1;
	assign sts.hit       = hit_q;

	logic [31:0] hit_age;
	assign hit_age   = clock_q - hit_stamp_q;
	assign sts.fresh = (hit_age <= lifetime_q);
	assign sts.held  = hit_q && (hit_age < holdoff_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_active_q <= 1'b0;
			scan_sel_q    <= 1'b0;
			chk_vld_s1    <= 1'b0;
			hit_q         <= 1'b0;
			best_set_q    <= 1'b0;
			iss_q         <= '0;
		end else if (cmd.scan_start) begin
			scan_active_q <= 1'b1;
			scan_sel_q    <= cmd.scan_hold;
			chk_vld_s1    <= 1'b0;
			hit_q         <= 1'b0;
			best_set_q    <= 1'b0;
			iss_q         <= '0;
		end else if (scan_active_q) begin
			if (iss_q != scan_len) begin
				iss_q      <= iss_q + SW'(1);
				chk_vld_s1 <= 1'b1;
			end else begin
				chk_vld_s1 <= 1'b0;
			end
			if (sts.scan_done) begin
				scan_active_q <= 1'b0;
			end
			if (chk_vld_s1 && chk_v) begin
				if (!hit_q && (chk_ip == cur_ip_q)) begin
					hit_q <= 1'b1;
				end
				if (!best_set_q || (chk_age > best_q)) begin
					best_set_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_active_q) begin
			chk_idx_s1 <= iss_q;
		end
		if (scan_active_q && chk_vld_s1 && chk_v) begin
			if (!hit_q && (chk_ip == cur_ip_q)) begin
				hit_idx_q   <= chk_idx_s1;
				hit_stamp_q <= chk_stamp;
				hit_mac_q   <= cache_rdata[79:32];
			end
			// oldest entry, lowest index wins a tie
			if (!best_set_q || (chk_age > best_q)) begin
				best_q   <= chk_age;
				oldest_q <= chk_idx_s1;
			end
		end
	end

	// replacement slot: matching entry, else first free, else oldest
	logic          c_free, h_free;
	logic [CW-1:0] c_free_idx;
	logic [HW-1:0] h_free_idx;

	always_comb begin
		c_free     = 1'b0;
		c_free_idx = '0;
		for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
			if (!cache_valid_q[i]) begin
				c_free     = 1'b1;
				c_free_idx = CW'(i);
			end
		end
	end

	always_comb begin
		h_free     = 1'b0;
		h_free_idx = '0;
		for (int i = HOLDOFF_ENTRIES - 1; i >= 0; i--) begin
			if (!hold_valid_q[i]) begin
				h_free     = 1'b1;
				h_free_idx = HW'(i);
			end
		end
	end

	assign c_slot = hit_q ? hit_idx_q[CW-1:0] : (c_free ? c_free_idx : oldest_q[CW-1:0]);
	assign h_slot = hit_q ? hit_idx_q[HW-1:0] : (h_free ? h_free_idx : oldest_q[HW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_valid_q <= '0;
			hold_valid_q  <= '0;
		end else begin
			if (cmd.cache_wr) begin
				cache_valid_q[c_slot] <= 1'b1;
			end
			if (cmd.hold_wr) begin
				hold_valid_q[h_slot] <= 1'b1;
			end
		end
	end

	// pending queue, re-run walks it in place
	logic [NW-1:0] count_q, rr_n_q, rr_k_q;
	logic          q_wr;
	assign q_wr       = cmd.q_push && (count_q < NW'(QUEUE_DEPTH));
	assign sts.q_more = (rr_k_q < rr_n_q);

	arpr_ram #(.WIDTH(48), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
		.clk   (clk),
		.we    (q_wr),
		.waddr (count_q[QW-1:0]),
		.wdata ({cur_handle_q, cur_ip_q}),
		.raddr (rr_k_q[QW-1:0]),
		.rdata (q_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rr_n_q  <= '0;
			rr_k_q  <= '0;
		end else begin
			if (cmd.rr_init) begin
				rr_n_q  <= count_q;
				rr_k_q  <= '0;
				count_q <= '0;
			end else if (q_wr) begin
				count_q <= count_q + NW'(1);
			end
			if (cmd.ld_q) begin
				rr_k_q <= rr_k_q + NW'(1);
			end
		end
	end

	// result staging: hold one result back so the last one can be marked
	arpr_pkg::result_t new_res, held_q, res_q, res_d;
	logic emit_any, held_vld_q, res_vld_q;

	assign emit_any = cmd.emit_ipv4 || cmd.emit_arp || cmd.emit_dlv;

	always_comb begin
		new_res = '0;
		if (cmd.emit_ipv4) begin
			new_res.result_kind = arpr_pkg::RES_IPV4;
			new_res.out_dst_mac = hit_mac_q;
			new_res.out_handle  = cur_handle_q;
		end else if (cmd.emit_arp) begin
			new_res.result_kind        = arpr_pkg::RES_ARP;
			new_res.out_dst_mac        = cur_dst_q;
			new_res.out_arp_op         = cur_op_q;
			new_res.out_arp_target_ip  = cur_ip_q;
			new_res.out_arp_target_mac = cur_op_q ? cur_dst_q : '0;
		end else begin
			new_res.result_kind = arpr_pkg::RES_DLV;
			new_res.out_handle  = item_q.datagram_handle;
		end
	end

	always_comb begin
		res_d             = held_q;
		res_d.last_result = 1'b0;
		if (cmd.finish) begin
			if (!held_vld_q) begin
				res_d             = '0;
				res_d.result_kind = arpr_pkg::RES_NONE;
			end
			res_d.last_result = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_vld_q <= 1'b0;
			res_vld_q  <= 1'b0;
		end else begin
			res_vld_q <= (emit_any && held_vld_q) || cmd.finish;
			if (emit_any) begin
				held_vld_q <= 1'b1;
			end else if (cmd.finish) begin
				held_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_any) begin
			held_q <= new_res;
		end
		if (emit_any || cmd.finish) begin
			res_q <= res_d;
		end
	end

	assign result_valid = res_vld_q;
	assign result       = res_q;

endmodule
